>>> hw/rtl/cd_pkg.sv
// ----------------------------------------------------------------------------
// cd_pkg
// Shared types and codes for the circular deque core and its cell chain.
// ----------------------------------------------------------------------------
package cd_pkg;

  localparam int unsigned DEPTH_DFLT = 16;
  localparam int unsigned WORD_W     = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               now_full;
    logic               now_empty;
  } out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic              en;
    req_e              req;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

>>> hw/rtl/cd_cell.sv
// ----------------------------------------------------------------------------
// cd_cell
// One slot of the deque. Holds the entry at this place counted from the
// front (fwd) and counted from the rear (rev), plus an occupied bit.
// ----------------------------------------------------------------------------
module cd_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cd_pkg::cell_ctl_t           ctl,
  input  logic                        lo_valid,
  input  logic [cd_pkg::WORD_W-1:0]   lo_fwd,
  input  logic [cd_pkg::WORD_W-1:0]   lo_rev,
  input  logic                        hi_valid,
  input  logic [cd_pkg::WORD_W-1:0]   hi_fwd,
  input  logic [cd_pkg::WORD_W-1:0]   hi_rev,
  output logic                        valid,
  output logic [cd_pkg::WORD_W-1:0]   fwd,
  output logic [cd_pkg::WORD_W-1:0]   rev
);

  logic                      valid_r, valid_nxt;
  logic [cd_pkg::WORD_W-1:0] fwd_r, fwd_nxt;
  logic [cd_pkg::WORD_W-1:0] rev_r, rev_nxt;
  logic                      tail_slot;

  // first free slot: an append lands here
  assign tail_slot = lo_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    fwd_nxt   = fwd_r;
    rev_nxt   = rev_r;
    if (ctl.en) begin
      unique case (ctl.req)
        cd_pkg::REQ_PUSH_FRONT: begin
          valid_nxt = lo_valid;
          fwd_nxt   = lo_fwd;
          if (tail_slot) rev_nxt = ctl.word;
        end
        cd_pkg::REQ_PUSH_REAR: begin
          valid_nxt = lo_valid;
          rev_nxt   = lo_rev;
          if (tail_slot) fwd_nxt = ctl.word;
        end
        cd_pkg::REQ_POP_FRONT: begin
          valid_nxt = hi_valid;
          fwd_nxt   = hi_fwd;
        end
        cd_pkg::REQ_POP_REAR: begin
          valid_nxt = hi_valid;
          rev_nxt   = hi_rev;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    rev_r <= rev_nxt;
  end

  assign valid = valid_r;
  assign fwd   = fwd_r;
  assign rev   = rev_r;

endmodule

>>> hw/rtl/cd_chain.sv
// ----------------------------------------------------------------------------
// cd_chain
// Row of DEPTH cells. Slot 0 is the head of both orderings; entries shift
// one slot per request toward or away from it.
// ----------------------------------------------------------------------------
module cd_chain #(
  parameter int unsigned DEPTH = cd_pkg::DEPTH_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cd_pkg::cell_ctl_t           ctl,
  output logic [cd_pkg::WORD_W-1:0]   front_word,
  output logic [cd_pkg::WORD_W-1:0]   rear_word,
  output logic                        empty,
  output logic                        full,
  output logic                        one_left
);

  logic [DEPTH-1:0]                  valid;
  logic [DEPTH-1:0][cd_pkg::WORD_W-1:0] fwd;
  logic [DEPTH-1:0][cd_pkg::WORD_W-1:0] rev;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      lo_valid, hi_valid;
    logic [cd_pkg::WORD_W-1:0] lo_fwd, lo_rev, hi_fwd, hi_rev;

    if (i == 0) begin : g_head
      assign lo_valid = 1'b1;
      assign lo_fwd   = ctl.word;
      assign lo_rev   = ctl.word;
    end else begin : g_mid_lo
      assign lo_valid = valid[i-1];
      assign lo_fwd   = fwd[i-1];
      assign lo_rev   = rev[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign hi_valid = 1'b0;
      assign hi_fwd   = ctl.word;
      assign hi_rev   = ctl.word;
    end else begin : g_mid_hi
      assign hi_valid = valid[i+1];
      assign hi_fwd   = fwd[i+1];
      assign hi_rev   = rev[i+1];
    end

    cd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .lo_valid (lo_valid),
      .lo_fwd   (lo_fwd),
      .lo_rev   (lo_rev),
      .hi_valid (hi_valid),
      .hi_fwd   (hi_fwd),
      .hi_rev   (hi_rev),
      .valid    (valid[i]),
      .fwd      (fwd[i]),
      .rev      (rev[i])
    );
  end

  assign front_word = fwd[0];
  assign rear_word  = rev[0];
  assign empty      = !valid[0];
  assign full       = valid[DEPTH-1];
  assign one_left   = valid[0] && !valid[1];

endmodule

>>> hw/rtl/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of DEPTH words built as a shifting chain of cells.
//
//   channel  dir  handshake              payload
//   in_      in   start & !busy          in_data  (cd_pkg::in_t)
//   out_     out  out_valid, one cycle   out_data (cd_pkg::out_t)
//
// One request per clock: the result of an accepted request is registered and
// shows in the cycle after acceptance. busy stays low; every cell shifts or
// appends in the same cycle, so no loop limits the rate.
// Synchronous active-low reset empties the deque; slot data is not cleared.
// The receiver cannot stall: out_data is valid only while out_valid is high.
// ----------------------------------------------------------------------------
module circular_deque_core #(
  parameter int unsigned DEPTH = cd_pkg::DEPTH_DFLT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  cd_pkg::in_t  in_data,
  output logic         out_valid,
  output cd_pkg::out_t out_data
);

  cd_pkg::cell_ctl_t         ctl;
  logic [cd_pkg::WORD_W-1:0] front_word, rear_word;
  logic                      empty, full, one_left;
  logic                      accept, is_push, refused;
  cd_pkg::req_e              req;

  logic                      out_valid_r, out_valid_nxt;
  logic [cd_pkg::WORD_W-1:0] pop_r, pop_nxt;
  cd_pkg::status_e           status_r, status_nxt;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign req     = cd_pkg::req_e'(in_data.req_type);
  assign is_push = (req == cd_pkg::REQ_PUSH_FRONT) || (req == cd_pkg::REQ_PUSH_REAR);
  assign refused = is_push ? full : empty;

  assign ctl.en   = accept && !refused;
  assign ctl.req  = req;
  assign ctl.word = in_data.push_value;

  cd_chain #(.DEPTH(DEPTH)) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .front_word (front_word),
    .rear_word  (rear_word),
    .empty      (empty),
    .full       (full),
    .one_left   (one_left)
  );

  always_comb begin
    out_valid_nxt = accept;
    pop_nxt       = '0;
    status_nxt    = cd_pkg::ST_DONE;
    if (refused) begin
      status_nxt = is_push ? cd_pkg::ST_FULL : cd_pkg::ST_EMPTY;
    end else begin
      unique case (req)
        cd_pkg::REQ_POP_FRONT: pop_nxt = front_word;
        cd_pkg::REQ_POP_REAR:  pop_nxt = rear_word;
        default:               pop_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_r    <= pop_nxt;
    status_r <= status_nxt;
  end

  // flags come straight from the cells, which already hold the post-step state
  assign out_valid          = out_valid_r;
  assign out_data.pop_value = pop_r;
  assign out_data.status    = status_r;
  assign out_data.now_full  = full;
  assign out_data.now_empty = empty;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_full_empty_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("deque flagged full and empty at once");

  a_push_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && !refused) |=> (out_valid && !out_data.now_empty))
    else $error("deque empty after a successful insert");

  a_pop_last : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && one_left) |=> (out_data.now_empty && !out_data.now_full))
    else $error("removing the last entry did not empty the deque");

  a_refused_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && refused) |=> ($stable(full) && $stable(empty) &&
                             out_data.status != cd_pkg::ST_DONE))
    else $error("refused request changed the deque");

endmodule

>>> sim/circular_deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_checker
// Watches the request and result channels of circular_deque_core, keeps its
// own copy of the ring, pointers and empty mark, and compares every result
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module circular_deque_checker #(
  parameter int unsigned DEPTH = cd_pkg::DEPTH_DFLT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  cd_pkg::in_t  in_data,
  input  logic         out_valid,
  input  cd_pkg::out_t out_data,
  output int           fail_count,
  output int           pending,
  output int           results_seen,
  output int           full_refusals,
  output int           empty_refusals
);

  logic [cd_pkg::WORD_W-1:0] slots [DEPTH];
  int unsigned               front_pos;
  int unsigned               rear_pos;
  logic                      is_empty;
  cd_pkg::out_t              expected_replies[$];

  function automatic int unsigned step_up(int unsigned p);
    return (p >= DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  function automatic logic is_full();
    return !is_empty && front_pos == step_up(rear_pos);
  endfunction

  // Applies one request to the shadow deque and returns the reply it must give
  function automatic cd_pkg::out_t apply_request(cd_pkg::in_t item);
    cd_pkg::out_t r;
    cd_pkg::req_e kind;
    kind = cd_pkg::req_e'(item.req_type);
    r = '0;
    r.status = cd_pkg::ST_DONE;
    if (kind == cd_pkg::REQ_PUSH_FRONT || kind == cd_pkg::REQ_PUSH_REAR) begin
      if (is_full()) begin
        r.status = cd_pkg::ST_FULL;
        full_refusals++;
      end else if (is_empty) begin
        // first entry always lands in slot zero
        front_pos = 0;
        rear_pos  = 0;
        is_empty  = 1'b0;
        slots[0]  = item.push_value;
      end else if (kind == cd_pkg::REQ_PUSH_FRONT) begin
        front_pos = step_down(front_pos);
        slots[front_pos] = item.push_value;
      end else begin
        rear_pos = step_up(rear_pos);
        slots[rear_pos] = item.push_value;
      end
    end else begin
      if (is_empty) begin
        r.status = cd_pkg::ST_EMPTY;
        empty_refusals++;
      end else begin
        r.pop_value = (kind == cd_pkg::REQ_POP_FRONT) ? slots[front_pos]
                                                      : slots[rear_pos];
        if (front_pos == rear_pos) begin
          is_empty  = 1'b1;
          front_pos = 0;
          rear_pos  = 0;
        end else if (kind == cd_pkg::REQ_POP_FRONT) begin
          front_pos = step_up(front_pos);
        end else begin
          rear_pos = step_down(rear_pos);
        end
      end
    end
    r.now_full  = is_full();
    r.now_empty = is_empty;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
    fail_count++;
  endtask

  initial begin
    fail_count     = 0;
    pending        = 0;
    results_seen   = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    front_pos      = 0;
    rear_pos       = 0;
    is_empty       = 1'b1;
  end

  always @(posedge clk) begin
    cd_pkg::out_t want;
    if (!rst_n) begin
      front_pos = 0;
      rear_pos  = 0;
      is_empty  = 1'b1;
      expected_replies.delete();
    end else begin
      // predict first so a same-cycle reply would still find its entry
      if (start && !busy)
        expected_replies.push_back(apply_request(in_data));
      if (out_valid) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t ns: result with nothing expected, got 0x%0h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_data.pop_value !== want.pop_value)
            report("pop_value", want.pop_value, out_data.pop_value);
          if (out_data.status !== want.status)
            report("status", 32'(want.status), 32'(out_data.status));
          if (out_data.now_full !== want.now_full)
            report("now_full", 32'(want.now_full), 32'(out_data.now_full));
          if (out_data.now_empty !== want.now_empty)
            report("now_empty", 32'(want.now_empty), 32'(out_data.now_empty));
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> sim/circular_deque_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_core_test
// Drives insert and remove requests into circular_deque_core: a directed
// pass over empty and full edges, then biased random fill/drain segments
// with random idle gaps. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module circular_deque_core_test;

  localparam int unsigned DEPTH       = cd_pkg::DEPTH_DFLT;
  localparam int          TOTAL_ITEMS = 1850;
  localparam int          QUIET_TAIL  = 200;
  localparam longint      LIMIT_NS    = 64'd4_000_000;

  logic         clk     = 1'b0;
  logic         rst_n   = 1'b0;
  logic         start   = 1'b0;
  cd_pkg::in_t  in_data = '0;
  logic         busy;
  logic         out_valid;
  cd_pkg::out_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int full_refusals;
  int empty_refusals;

  int issued  = 0;
  int inserts = 0;
  int removals = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_deque_core #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  circular_deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  // start stays high from one request to the next; it drops in idle_gap and after the last request
  task automatic send(cd_pkg::req_e kind, logic [31:0] word);
    cd_pkg::in_t item;
    item.req_type   = kind;
    item.push_value = word;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    issued++;
    if (kind == cd_pkg::REQ_PUSH_FRONT || kind == cd_pkg::REQ_PUSH_REAR) inserts++;
    else removals++;
  endtask

  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int           seg_len;
    int           push_pct;
    bit           quiet;
    bit           is_push;
    cd_pkg::req_e kind;
    int           guard;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // removals from an empty deque
    send(cd_pkg::REQ_POP_FRONT, $urandom);
    send(cd_pkg::REQ_POP_REAR, $urandom);
    // first insert through the rear, then take the last entry from the front
    send(cd_pkg::REQ_PUSH_REAR, 32'h8000_0000);
    send(cd_pkg::REQ_POP_FRONT, $urandom);
    // fill to full from both ends; front wraps below zero right away
    send(cd_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    for (int i = 1; i < DEPTH; i++) begin
      case (i)
        1:       send(cd_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        2:       send(cd_pkg::REQ_PUSH_REAR, 32'hFFFF_FFFF);
        3:       send(cd_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        4:       send(cd_pkg::REQ_PUSH_REAR, 32'h5555_5555);
        default: send((i % 2) ? cd_pkg::REQ_PUSH_FRONT : cd_pkg::REQ_PUSH_REAR, $urandom);
      endcase
    end
    send(cd_pkg::REQ_PUSH_FRONT, $urandom);
    send(cd_pkg::REQ_PUSH_REAR, $urandom);
    send(cd_pkg::REQ_POP_REAR, $urandom);
    send(cd_pkg::REQ_POP_FRONT, $urandom);

    // segments lean toward filling, draining or neither, so both full and
    // empty are reached over and over with the pointers at every position
    while (issued < TOTAL_ITEMS) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      quiet = ($urandom_range(0, 9) < 3);
      for (int n = 0; n < seg_len && issued < TOTAL_ITEMS; n++) begin
        if (!quiet && issued < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
          idle_gap($urandom_range(1, 12));
        is_push = ($urandom_range(1, 100) <= push_pct);
        if (is_push) kind = $urandom_range(0, 1) ? cd_pkg::REQ_PUSH_REAR : cd_pkg::REQ_PUSH_FRONT;
        else         kind = $urandom_range(0, 1) ? cd_pkg::REQ_POP_REAR : cd_pkg::REQ_POP_FRONT;
        send(kind, pick_word());
      end
    end
    start <= 1'b0;

    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < 1000);
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Ran %0d requests (%0d inserts, %0d removals); %0d results checked.",
             issued, inserts, removals, results_seen);
    $display("Inserts refused as full: %0d, removals refused as empty: %0d.",
             full_refusals, empty_refusals);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
